/* src/cbg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbg_pkg: shared types and constants of the code byte generator
// register indexes, output forms, range cell layout and result layout
// ----------------------------------------------------------------------------
package cbg_pkg;

  // cells searched in table mode, at most NUM_CELLS
  localparam int CELL_SLOTS = 6;
  // range cell registers that exist
  localparam int NUM_CELLS  = 6;

  localparam int CODE_W  = 16;
  localparam int SPACE_W = 3;
  localparam int COUNT_W = 3;
  localparam int MODE_W  = 4;
  localparam int CFG_W   = 38;
  localparam int IDX_W   = 3;

  // register indexes
  localparam logic [IDX_W-1:0] REG_CHARSET_MODE = 3'd0;
  localparam logic [IDX_W-1:0] REG_CELL_COUNT   = 3'd1;
  localparam int               REG_CELL_0       = 2;

  // charset modes
  localparam logic [MODE_W-1:0] MODE_ONE_BYTE = 4'd0;
  localparam logic [MODE_W-1:0] MODE_TWO_BE   = 4'd1;
  localparam logic [MODE_W-1:0] MODE_TABLE    = 4'd2;
  localparam logic [MODE_W-1:0] MODE_GR       = 4'd3;
  localparam logic [MODE_W-1:0] MODE_SS3      = 4'd4;
  localparam logic [MODE_W-1:0] MODE_SS2_A2   = 4'd5;
  localparam logic [MODE_W-1:0] MODE_TWO_LE   = 4'd6;
  localparam logic [MODE_W-1:0] MODE_PAD_HEAD = 4'd7;
  localparam logic [MODE_W-1:0] MODE_PAD_TAIL = 4'd8;

  // table sub-forms
  localparam logic [2:0] FORM_ONE_BYTE = 3'd0;
  localparam logic [2:0] FORM_TWO_BYTE = 3'd1;
  localparam logic [2:0] FORM_GR       = 3'd2;
  localparam logic [2:0] FORM_SS2      = 3'd3;
  localparam logic [2:0] FORM_UTF8_2   = 3'd4;
  localparam logic [2:0] FORM_UTF8_3   = 3'd5;

  localparam logic [7:0] BYTE_SS2   = 8'h8E;
  localparam logic [7:0] BYTE_A2    = 8'hA2;
  localparam logic [7:0] BYTE_SS3   = 8'h8F;
  localparam logic [7:0] BYTE_HIGH  = 8'h80;
  localparam logic [7:0] BYTE_LEAD2 = 8'hC0;
  localparam logic [7:0] BYTE_LEAD3 = 8'hE0;

  localparam logic [COUNT_W-1:0] MAX_BYTES = 3'd4;

  typedef struct packed {
    logic [2:0] len;
    logic [2:0] form;
    logic [7:0] max_hb;
    logic [7:0] min_hb;
    logic [7:0] max_lb;
    logic [7:0] min_lb;
  } cbg_cell_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] form;
    logic [2:0] len;
  } cbg_match_t;

  typedef struct packed {
    logic               ok;
    logic [COUNT_W-1:0] byte_count;
    logic [3:0][7:0]    bytes;
  } cbg_result_t;

endpackage

/* src/cbg_cell_match.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbg_cell_match: range cell search
// compares a code against the first cell_count cells at once, lowest cell wins
// ----------------------------------------------------------------------------
module cbg_cell_match (
  input  logic [cbg_pkg::CODE_W-1:0] code,
  input  logic [2:0]                 cell_count,
  input  cbg_pkg::cbg_cell_t         cells [cbg_pkg::NUM_CELLS],
  output cbg_pkg::cbg_match_t        match
);
  import cbg_pkg::*;

  logic [7:0] hi;
  logic [7:0] lo;

  assign hi = code[15:8];
  assign lo = code[7:0];

  always_comb begin
    match = '0;
    // walk down so the lowest matching cell is left standing
    for (int i = NUM_CELLS - 1; i >= 0; i--) begin
      if (i < CELL_SLOTS && 3'(i) < cell_count &&
          lo >= cells[i].min_lb && lo <= cells[i].max_lb &&
          hi >= cells[i].min_hb && hi <= cells[i].max_hb) begin
        match.hit  = 1'b1;
        match.form = cells[i].form;
        match.len  = cells[i].len;
      end
    end
  end

endmodule

/* src/cbg_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbg_encoder: byte formatter
// builds the output bytes, count and ok flag for one code
// ----------------------------------------------------------------------------
module cbg_encoder (
  input  logic [cbg_pkg::MODE_W-1:0]  charset_mode,
  input  logic [cbg_pkg::CODE_W-1:0]  code,
  input  logic [cbg_pkg::SPACE_W-1:0] space_avail,
  input  cbg_pkg::cbg_match_t         match,
  output cbg_pkg::cbg_result_t        result
);
  import cbg_pkg::*;

  logic [7:0]         hi;
  logic [7:0]         lo;
  logic [3:0][7:0]    raw;
  logic [COUNT_W-1:0] need;
  logic               valid_form;
  logic [COUNT_W-1:0] tbl_len;

  assign hi = code[15:8];
  assign lo = code[7:0];
  // cell lengths above four count as four
  assign tbl_len = (match.len > MAX_BYTES) ? MAX_BYTES : match.len;

  always_comb begin
    raw        = '0;
    need       = '0;
    valid_form = 1'b1;
    case (charset_mode)
      MODE_ONE_BYTE: begin
        need = 3'd1; raw[0] = lo;
      end
      MODE_TWO_BE: begin
        need = 3'd2; raw[0] = hi; raw[1] = lo;
      end
      MODE_GR: begin
        need = 3'd2; raw[0] = hi | BYTE_HIGH; raw[1] = lo | BYTE_HIGH;
      end
      MODE_SS3: begin
        need = 3'd3; raw[0] = BYTE_SS3;
        raw[1] = hi | BYTE_HIGH; raw[2] = lo | BYTE_HIGH;
      end
      MODE_SS2_A2: begin
        need = 3'd4; raw[0] = BYTE_SS2; raw[1] = BYTE_A2;
        raw[2] = hi | BYTE_HIGH; raw[3] = lo | BYTE_HIGH;
      end
      MODE_TWO_LE: begin
        need = 3'd2; raw[0] = lo; raw[1] = hi;
      end
      MODE_PAD_HEAD: begin
        need = 3'd4; raw[2] = hi; raw[3] = lo;
      end
      MODE_PAD_TAIL: begin
        need = 3'd4; raw[0] = hi; raw[1] = lo;
      end
      MODE_TABLE: begin
        need       = tbl_len;
        valid_form = match.hit;
        case (match.form)
          FORM_ONE_BYTE: raw[0] = lo;
          FORM_TWO_BYTE: begin
            raw[0] = hi; raw[1] = lo;
          end
          FORM_GR: begin
            raw[0] = hi | BYTE_HIGH; raw[1] = lo | BYTE_HIGH;
          end
          FORM_SS2: begin
            raw[0] = BYTE_SS2; raw[1] = lo;
          end
          FORM_UTF8_2: begin
            raw[0] = BYTE_LEAD2 | {3'b000, code[10:6]};
            raw[1] = BYTE_HIGH | {2'b00, code[5:0]};
          end
          FORM_UTF8_3: begin
            raw[0] = BYTE_LEAD3 | {4'b0000, code[15:12]};
            raw[1] = BYTE_HIGH | {2'b00, code[11:6]};
            raw[2] = BYTE_HIGH | {2'b00, code[5:0]};
          end
          default: valid_form = 1'b0;
        endcase
      end
      default: valid_form = 1'b0;
    endcase
  end

  always_comb begin
    result = '0;
    if (valid_form && space_avail >= need) begin
      result.ok         = 1'b1;
      result.byte_count = need;
      for (int k = 0; k < 4; k++) begin
        // bytes at or past the count stay zero
        if (3'(k) < need) result.bytes[k] = raw[k];
      end
    end
  end

endmodule

/* src/charset_code_byte_generator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// charset_code_byte_generator_unit: multibyte code generator
// encodes a 16-bit character code into up to four bytes in a fixed or
// range-table selected form
// ----------------------------------------------------------------------------
//  channel   direction  handshake              item
//  s_*       in         s_tvalid / s_tready    code, space_avail
//  m_*       out        m_tvalid / m_tready    ok, count, four bytes
//  cfg_*     in         cfg_wen                register write, no read-back
//
//  one item per cycle while the result is not stalled by m_tready; the result
//  passes through the input register, then the result register, before it
//  can be taken at the output
//  the six range cells are compared in parallel, combinationally, which sets
//  the path between the two registers
//  rst clears the configuration registers and both valid flags
//  a stalled result holds in the result register while the input register
//  can still take one item, after which it is full
// ----------------------------------------------------------------------------
module charset_code_byte_generator_unit (
  input  logic                        clk,
  input  logic                        rst,
  // code [15:0], space_avail [18:16], zero padding [23:19]
  input  logic [23:0]                 s_tdata,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // byte_count [2:0], byte_first [10:3], byte_second [18:11],
  // byte_third [26:19], byte_fourth [34:27], zero padding [39:35]
  output logic [39:0]                 m_tdata,
  // ok [0]
  output logic                        m_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic                        cfg_wen,
  input  logic [cbg_pkg::IDX_W-1:0]   cfg_index,
  input  logic [cbg_pkg::CFG_W-1:0]   cfg_wdata
);
  import cbg_pkg::*;

  // configuration registers
  logic [MODE_W-1:0] charset_mode;
  logic [2:0]        cell_count;
  cbg_cell_t         cells [NUM_CELLS];

  // input register
  logic               s1_valid;
  logic [CODE_W-1:0]  s1_code;
  logic [SPACE_W-1:0] s1_space;
  logic               s1_adv;

  // result register
  logic        s2_valid;
  cbg_result_t s2_res;

  cbg_match_t  match;
  cbg_result_t result_next;

  // input stage moves on when the result register is empty or being drained
  assign s1_adv   = s1_valid && (!s2_valid || m_tready);
  assign s_tready = !s1_valid || s1_adv;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      charset_mode <= '0;
      cell_count   <= '0;
      for (int i = 0; i < NUM_CELLS; i++) cells[i] <= '0;
    end else if (cfg_wen) begin
      if (cfg_index == REG_CHARSET_MODE) charset_mode <= cfg_wdata[MODE_W-1:0];
      if (cfg_index == REG_CELL_COUNT)   cell_count   <= cfg_wdata[2:0];
      for (int i = 0; i < NUM_CELLS; i++) begin
        if (cfg_index == IDX_W'(REG_CELL_0 + i)) cells[i] <= cbg_cell_t'(cfg_wdata);
      end
    end
  end

  // pipeline valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) s1_valid <= 1'b1;
      else if (s1_adv)          s1_valid <= 1'b0;
      if (s1_adv)               s2_valid <= 1'b1;
      else if (m_tready)        s2_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_code  <= s_tdata[15:0];
      s1_space <= s_tdata[18:16];
    end
    if (s1_adv) s2_res <= result_next;
  end

  cbg_cell_match u_match (
    .code       (s1_code),
    .cell_count (cell_count),
    .cells      (cells),
    .match      (match)
  );

  cbg_encoder u_encoder (
    .charset_mode (charset_mode),
    .code         (s1_code),
    .space_avail  (s1_space),
    .match        (match),
    .result       (result_next)
  );

  assign m_tvalid = s2_valid;
  assign m_tuser  = s2_res.ok;
  assign m_tdata  = {5'b00000, s2_res.bytes[3], s2_res.bytes[2], s2_res.bytes[1],
                     s2_res.bytes[0], s2_res.byte_count};

`ifndef SYNTH
  // a failed result carries no count and no bytes
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("failed result with nonzero data");

  // bytes past a count of one stay zero
  a_one_byte: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] == 3'd1 |-> m_tdata[34:11] == '0)
    else $error("bytes past count not zero");

  // a held input item is not overwritten
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_code) && $stable(s1_space))
    else $error("input register lost a held item");

  // an accepted item lands in the input register
  a_s1_load: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> s1_valid)
    else $error("accepted item not captured");
`endif

endmodule
